>>> rtl/tes_pkg.sv
package tes_pkg;

  localparam int unsigned MaxTimers = 16;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned SeqW    = 16;
  localparam int unsigned HSlotW  = 4;
  localparam int unsigned MinW    = 16;
  localparam logic [MinW-1:0] MinDelayReset = 16'd100;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_FIRED  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    func_t               func;
    logic [TimeW-1:0]    now_us;
    logic [TimeW-1:0]    expire_at_us;
    logic [PeriodW-1:0]  period_us;
    logic [HSlotW-1:0]   handle_slot;
    logic [SeqW-1:0]     handle_seq;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ANSWER,
    S_FIRE,
    S_UPDATE,
    S_DONE
  } state_t;

endpackage

>>> rtl/timer_expiry_scheduler.sv
// Timer table with add, cancel and tick operations. An add or cancel makes
// one scan of the table for the earliest expiry; a tick makes an initial
// scan, then one table scan per due entry in expiry order and a final scan
// for the next alarm; a stalled result output holds the block up. The table
// holds MAX_TIMERS = 16 slots. A two-entry command queue lets input run ahead
// of the table.
module timer_expiry_scheduler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[1:0], now_us[49:2], expire_at_us[97:50], period_us[129:98],
  // handle_slot[133:130], handle_seq[149:134], zero fill
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // slot[3:0], seq[19:4], status[21:20], rearm[22], rearm_delay_us[70:23],
  // pending_count[75:71], zero fill
  output logic [79:0]  m_axis_tdata,
  // kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  tes_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [tes_pkg::MinW-1:0] min_delay;
  tes_pkg::kind_t kind;
  tes_pkg::status_t status;
  logic [3:0] slot;
  logic [15:0] seq;
  logic rearm;
  logic [47:0] delay;
  logic [4:0] pend;

  assign in_cmd.func         = tes_pkg::func_t'(s_axis_tdata[1:0]);
  assign in_cmd.now_us       = s_axis_tdata[49:2];
  assign in_cmd.expire_at_us = s_axis_tdata[97:50];
  assign in_cmd.period_us    = s_axis_tdata[129:98];
  assign in_cmd.handle_slot  = s_axis_tdata[133:130];
  assign in_cmd.handle_seq   = s_axis_tdata[149:134];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay <= tes_pkg::MinDelayReset;
    end else if (cfg_valid) begin
      min_delay <= cfg_data;
    end
  end

  tes_front #(.DEPTH(2)) u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (in_cmd),
    .q_valid, .q_ready, .q_cmd
  );

  tes_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .min_delay,
    .o_valid  (m_axis_tvalid),
    .o_ready  (m_axis_tready),
    .o_kind   (kind),
    .o_slot   (slot),
    .o_seq    (seq),
    .o_status (status),
    .o_rearm  (rearm),
    .o_delay  (delay),
    .o_pend   (pend),
    .o_last   (m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {4'b0, pend, delay, rearm, status, seq, slot};

endmodule

>>> rtl/tes_front.sv
module tes_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tes_pkg::cmd_t        in_cmd,
  output logic                 q_valid,
  input  logic                 q_ready,
  output tes_pkg::cmd_t        q_cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tes_pkg::cmd_t   mem [DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [AW:0]     cnt;
  logic            push;
  logic            pop;

  assign in_ready = (cnt != (AW+1)'(DEPTH));
  // drop unused operation codes here
  assign push     = in_valid && in_ready && (in_cmd.func != tes_pkg::FUNC_NONE);
  assign q_valid  = (cnt != '0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_cmd;
    end
  end

endmodule

>>> rtl/tes_back.sv
module tes_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  tes_pkg::cmd_t              q_cmd,
  input  logic [tes_pkg::MinW-1:0]   min_delay,
  output logic                       o_valid,
  input  logic                       o_ready,
  output tes_pkg::kind_t             o_kind,
  output logic [3:0]                 o_slot,
  output logic [tes_pkg::SeqW-1:0]   o_seq,
  output tes_pkg::status_t           o_status,
  output logic                       o_rearm,
  output logic [tes_pkg::TimeW-1:0]  o_delay,
  output logic [4:0]                 o_pend,
  output logic                       o_last
);

  localparam int unsigned N  = tes_pkg::MaxTimers;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = $clog2(N + 1);
  localparam logic [tes_pkg::TimeW-1:0] TMAX = '1;

  tes_pkg::state_t state, state_next;

  logic [N-1:0]                valid;
  logic [N-1:0]                enabled;
  logic [tes_pkg::TimeW-1:0]   expire [N];
  logic [tes_pkg::PeriodW-1:0] period [N];
  logic [tes_pkg::SeqW-1:0]    seqs   [N];
  logic [tes_pkg::SeqW-1:0]    next_seq;

  tes_pkg::cmd_t cmd;
  logic [IW:0]   idx;
  logic [IW-1:0] ix;
  logic          have_min;
  logic [tes_pkg::TimeW-1:0] min_exp;
  logic          have_due;
  logic [tes_pkg::TimeW-1:0] due_exp;
  logic [IW-1:0] due_ix;
  logic [4:0]    nfired;
  logic [N-1:0]  done_due;
  logic [CW-1:0] keep_cnt;
  logic          do_emit;
  logic          out_full;
  logic          fire_hit;
  logic          load_out;

  assign ix      = idx[IW-1:0];
  assign q_ready = (state == tes_pkg::S_IDLE);
  assign o_valid = out_full;
  assign do_emit = !out_full || o_ready;

  logic [CW-1:0] pend_c;
  always_comb begin
    pend_c = '0;
    for (int i = 0; i < N; i++) begin
      pend_c = pend_c + CW'(valid[i]);
    end
  end

  logic         any_free;
  logic [IW-1:0] free_ix;
  always_comb begin
    any_free = 1'b0;
    free_ix  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        any_free = 1'b1;
        free_ix  = IW'(i);
      end
    end
  end

  function automatic logic [tes_pkg::TimeW-1:0] delay_to(
    input logic [tes_pkg::TimeW-1:0] e,
    input logic [tes_pkg::TimeW-1:0] n,
    input logic [tes_pkg::MinW-1:0]  m
  );
    logic [tes_pkg::TimeW-1:0] d;
    d = (e > n) ? e - n : '0;
    if (d < tes_pkg::TimeW'(m)) begin
      d = tes_pkg::TimeW'(m);
    end
    return d;
  endfunction

  logic scan_end;
  assign scan_end = (idx == (IW+1)'(N - 1)) || (idx >= (IW+1)'(N));

  logic fire_scan;
  assign fire_hit = !fire_scan && have_due && enabled[due_ix] && (nfired < 5'd16);
  assign load_out = do_emit && ((state == tes_pkg::S_ANSWER) ||
                                (state == tes_pkg::S_FIRE && fire_hit) ||
                                (state == tes_pkg::S_DONE && idx >= (IW+1)'(N)));

  always_comb begin
    state_next = state;
    case (state)
      tes_pkg::S_IDLE:   if (q_valid) state_next = tes_pkg::S_SCAN;
      tes_pkg::S_SCAN:   if (scan_end) begin
        state_next = (cmd.func == tes_pkg::FUNC_TICK) ? tes_pkg::S_FIRE
                                                     : tes_pkg::S_ANSWER;
      end
      tes_pkg::S_ANSWER: if (do_emit) state_next = tes_pkg::S_IDLE;
      tes_pkg::S_FIRE:   if (!fire_scan && !have_due) state_next = tes_pkg::S_UPDATE;
      tes_pkg::S_UPDATE: state_next = tes_pkg::S_DONE;
      tes_pkg::S_DONE:   if (idx >= (IW+1)'(N) && do_emit) state_next = tes_pkg::S_IDLE;
      default:           state_next = tes_pkg::S_IDLE;
    endcase
  end

  // FIRE: each pass picks the earliest unprocessed due entry (one table scan
  // per due entry); UPDATE/DONE rescans for the earliest remaining expiry.
  logic [IW:0] sidx;
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tes_pkg::S_IDLE;
      valid    <= '0;
      enabled  <= '0;
      next_seq <= '0;
      out_full <= 1'b0;
      idx      <= '0;
      sidx     <= '0;
      fire_scan <= 1'b0;
      have_min <= 1'b0;
      have_due <= 1'b0;
      nfired   <= '0;
      done_due <= '0;
      keep_cnt <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_full <= 1'b1;
      end else if (o_ready) begin
        out_full <= 1'b0;
      end
      case (state)
        tes_pkg::S_IDLE: begin
          cmd      <= q_cmd;
          idx      <= '0;
          have_min <= 1'b0;
          nfired   <= '0;
          done_due <= '0;
          keep_cnt <= '0;
        end
        tes_pkg::S_SCAN: begin
          if (idx < (IW+1)'(N) && valid[ix] && (!have_min || expire[ix] < min_exp)) begin
            have_min <= 1'b1;
            min_exp  <= expire[ix];
          end
          if (idx < (IW+1)'(N) && valid[ix] &&
              !(expire[ix] <= cmd.now_us && (!enabled[ix] || period[ix] == '0))) begin
            keep_cnt <= keep_cnt + 1'b1;
          end
          idx <= idx + 1'b1;
          if (scan_end) begin
            sidx      <= '0;
            fire_scan <= 1'b1;
            have_due  <= 1'b0;
          end
        end
        tes_pkg::S_ANSWER: if (do_emit) begin
          o_delay  <= '0;
          o_rearm  <= 1'b0;
          o_last   <= 1'b1;
          if (cmd.func == tes_pkg::FUNC_ADD) begin
            o_kind <= tes_pkg::KIND_ADD;
            if (!any_free) begin
              o_slot   <= '0;
              o_seq    <= '0;
              o_status <= tes_pkg::ST_FULL;
              o_pend   <= 5'(pend_c);
            end else begin
              o_slot   <= 4'(free_ix);
              o_seq    <= next_seq;
              o_status <= tes_pkg::ST_OK;
              o_pend   <= 5'(pend_c) + 5'd1;
              if (!have_min || cmd.expire_at_us < min_exp) begin
                o_rearm <= 1'b1;
                o_delay <= delay_to(cmd.expire_at_us, cmd.now_us, min_delay);
              end
              next_seq         <= next_seq + 1'b1;
              valid[free_ix]   <= 1'b1;
              enabled[free_ix] <= 1'b1;
              expire[free_ix]  <= cmd.expire_at_us;
              period[free_ix]  <= cmd.period_us;
              seqs[free_ix]    <= next_seq;
            end
          end else begin
            o_kind <= tes_pkg::KIND_CANCEL;
            o_slot <= cmd.handle_slot;
            o_seq  <= cmd.handle_seq;
            o_pend <= 5'(pend_c);
            if (32'(cmd.handle_slot) < N && valid[IW'(cmd.handle_slot)] &&
                seqs[IW'(cmd.handle_slot)] == cmd.handle_seq) begin
              enabled[IW'(cmd.handle_slot)] <= 1'b0;
              o_status <= tes_pkg::ST_OK;
            end else begin
              o_status <= tes_pkg::ST_MISMATCH;
            end
          end
        end
        tes_pkg::S_FIRE: begin
          if (fire_scan) begin
            if (sidx < (IW+1)'(N)) begin
              if (valid[sidx[IW-1:0]] && !done_due[sidx[IW-1:0]] &&
                  expire[sidx[IW-1:0]] <= cmd.now_us &&
                  (!have_due || expire[sidx[IW-1:0]] < due_exp)) begin
                have_due <= 1'b1;
                due_exp  <= expire[sidx[IW-1:0]];
                due_ix   <= sidx[IW-1:0];
              end
              sidx <= sidx + 1'b1;
            end else begin
              fire_scan <= 1'b0;
            end
          end else if (have_due) begin
            // firings carry the post-tick pending count, so mark and defer frees
            if (enabled[due_ix] && nfired < 5'd16) begin
              if (do_emit) begin
                o_kind   <= tes_pkg::KIND_FIRED;
                o_slot   <= 4'(due_ix);
                o_seq    <= seqs[due_ix];
                o_status <= tes_pkg::ST_OK;
                o_rearm  <= 1'b0;
                o_delay  <= '0;
                o_pend   <= 5'(keep_cnt);
                o_last   <= 1'b0;
                nfired   <= nfired + 1'b1;
                done_due[due_ix] <= 1'b1;
                have_due <= 1'b0;
                fire_scan <= 1'b1;
                sidx     <= '0;
              end
            end else begin
              done_due[due_ix] <= 1'b1;
              have_due <= 1'b0;
              fire_scan <= 1'b1;
              sidx     <= '0;
            end
          end
        end
        tes_pkg::S_UPDATE: begin
          for (int i = 0; i < N; i++) begin
            if (done_due[i]) begin
              if (!enabled[i] || period[i] == '0) begin
                valid[i]   <= 1'b0;
                enabled[i] <= 1'b0;
              end else begin
                expire[i] <= ({1'b0, cmd.now_us} + (tes_pkg::TimeW+1)'(period[i]) > {1'b0, TMAX})
                             ? TMAX : cmd.now_us + tes_pkg::TimeW'(period[i]);
              end
            end
          end
          idx      <= '0;
          have_min <= 1'b0;
        end
        tes_pkg::S_DONE: begin
          if (idx < (IW+1)'(N)) begin
            if (valid[ix] && (!have_min || expire[ix] < min_exp)) begin
              have_min <= 1'b1;
              min_exp  <= expire[ix];
            end
            idx <= idx + 1'b1;
          end else if (do_emit) begin
            o_kind   <= tes_pkg::KIND_DONE;
            o_slot   <= '0;
            o_seq    <= '0;
            o_status <= tes_pkg::ST_OK;
            o_rearm  <= have_min;
            o_delay  <= have_min ? delay_to(min_exp, cmd.now_us, min_delay) : '0;
            o_pend   <= 5'(pend_c);
            o_last   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    o_valid && o_kind == tes_pkg::KIND_FIRED |-> !o_last && !o_rearm)
    else $error("firing flags wrong");
  assert property (@(posedge clk) disable iff (rst)
    nfired <= 5'd16)
    else $error("too many firings");
  assert property (@(posedge clk) disable iff (rst)
    (enabled & ~valid) == '0)
    else $error("enabled free slot");

endmodule
